// File: src/prfm_pkg.sv
// Package: shared types, constants and helpers for the packet rule filter.
`timescale 1ns / 1ps
package prfm_pkg;

    localparam int RULES_PER_KIND = 8;
    localparam int CNT_W          = $clog2(RULES_PER_KIND + 1);
    localparam int IDX_W          = (RULES_PER_KIND > 1) ? $clog2(RULES_PER_KIND) : 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W      = 120;
    localparam int S_TUSER_W      = 3;
    localparam int M_TDATA_W      = 8;

    typedef enum logic [2:0] {
        OP_NE = 3'd0,
        OP_EQ = 3'd1,
        OP_GT = 3'd2,
        OP_LT = 3'd3,
        OP_GE = 3'd4,
        OP_LE = 3'd5
    } t_rule_op;

    typedef enum logic [1:0] {
        KIND_WAN  = 2'd0,
        KIND_LAN  = 2'd1,
        KIND_PORT = 2'd2
    } t_rule_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_OP = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic        is_match;
        logic        bad_op;
        logic [1:0]  kind;
        logic [2:0]  opc;
        logic [31:0] value;
        logic [31:0] wan_addr;
        logic        wan_present;
        logic [31:0] lan_addr;
        logic        lan_present;
        logic [15:0] port_number;
        logic        port_present;
    } t_cmd;

    function automatic logic port_rule_holds(input logic [2:0] opc, input logic [31:0] rv,
                                             input logic [15:0] p);
        logic [31:0] pw;
        logic        res;
        pw = {16'd0, p};
        unique case (opc)
            OP_NE:   res = (pw != rv);
            OP_EQ:   res = (pw == rv);
            OP_GT:   res = (pw > rv);
            OP_LT:   res = (pw < rv);
            OP_GE:   res = (pw >= rv);
            OP_LE:   res = (pw <= rv);
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: src/prfm_front.sv
// Front end: unpacks input beats, classifies them and checks rule operators.
`timescale 1ns / 1ps
module prfm_front
    import prfm_pkg::*;
(
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic bad;

    always_comb begin
        o_cmd.is_match     = i_s_tuser[0];
        o_cmd.kind         = i_s_tuser[2:1];
        o_cmd.opc          = i_s_tdata[2:0];
        o_cmd.value        = i_s_tdata[34:3];
        o_cmd.wan_addr     = i_s_tdata[66:35];
        o_cmd.wan_present  = i_s_tdata[67];
        o_cmd.lan_addr     = i_s_tdata[99:68];
        o_cmd.lan_present  = i_s_tdata[100];
        o_cmd.port_number  = i_s_tdata[116:101];
        o_cmd.port_present = i_s_tdata[117];

        unique case (i_s_tuser[2:1])
            KIND_WAN, KIND_LAN: bad = (i_s_tdata[2:0] != OP_NE) && (i_s_tdata[2:0] != OP_EQ);
            KIND_PORT:          bad = (i_s_tdata[2:0] > OP_LE);
            default:            bad = 1'b1;
        endcase
        o_cmd.bad_op = bad;
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

endmodule

// File: src/prfm_queue.sv
// Command queue: short register FIFO between the front and back ends.
`timescale 1ns / 1ps
module prfm_queue
    import prfm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

// File: src/prfm_back.sv
// Back end: rule tables, parallel match and registered result beat.
`timescale 1ns / 1ps
module prfm_back
    import prfm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pass_all,
    input  logic                 i_q_empty,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [31:0]      r_wan_val  [RULES_PER_KIND];
    logic             r_wan_eq   [RULES_PER_KIND];
    logic [31:0]      r_lan_val  [RULES_PER_KIND];
    logic             r_lan_eq   [RULES_PER_KIND];
    logic [31:0]      r_port_val [RULES_PER_KIND];
    logic [2:0]       r_port_op  [RULES_PER_KIND];
    logic [CNT_W-1:0] r_wan_cnt, r_lan_cnt, r_port_cnt;
    logic             r_out_valid;
    logic [1:0]       r_status, n_status;
    logic             r_matched, n_matched;

    logic wan_any, lan_any, port_all, full, do_add;
    logic wan_ok, lan_ok, port_ok;
    logic [CNT_W-1:0] sel_cnt;

    assign o_pop = !i_q_empty && (!r_out_valid || i_m_tready);

    always_comb begin
        wan_any  = 1'b0;
        lan_any  = 1'b0;
        port_all = 1'b1;
        for (int i = 0; i < RULES_PER_KIND; i++) begin
            if (CNT_W'(i) < r_wan_cnt &&
                (r_wan_eq[i] == (r_wan_val[i] == i_cmd.wan_addr))) begin
                wan_any = 1'b1;
            end
            if (CNT_W'(i) < r_lan_cnt &&
                (r_lan_eq[i] == (r_lan_val[i] == i_cmd.lan_addr))) begin
                lan_any = 1'b1;
            end
            if (CNT_W'(i) < r_port_cnt &&
                !port_rule_holds(r_port_op[i], r_port_val[i], i_cmd.port_number)) begin
                port_all = 1'b0;
            end
        end

        wan_ok  = (r_wan_cnt == '0) || (i_cmd.wan_present && wan_any);
        lan_ok  = (r_lan_cnt == '0) || (i_cmd.lan_present && lan_any);
        port_ok = (r_port_cnt == '0) || (i_cmd.port_present && port_all);

        unique case (i_cmd.kind)
            KIND_WAN:  sel_cnt = r_wan_cnt;
            KIND_LAN:  sel_cnt = r_lan_cnt;
            default:   sel_cnt = r_port_cnt;
        endcase
        full   = (sel_cnt >= CNT_W'(RULES_PER_KIND));
        do_add = o_pop && !i_cmd.is_match && !i_cmd.bad_op && !full;

        n_status  = ST_OK;
        n_matched = 1'b0;
        if (i_cmd.is_match) begin
            if (i_pass_all) begin
                n_matched = 1'b1;
            end else if ((r_wan_cnt == '0 && r_lan_cnt == '0 && r_port_cnt == '0) ||
                         (!i_cmd.wan_present && !i_cmd.lan_present && !i_cmd.port_present)) begin
                n_matched = 1'b0;
            end else begin
                n_matched = wan_ok && lan_ok && port_ok;
            end
        end else if (i_cmd.bad_op) begin
            n_status = ST_BAD_OP;
        end else if (full) begin
            n_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wan_cnt   <= '0;
            r_lan_cnt   <= '0;
            r_port_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_add) begin
                unique case (i_cmd.kind)
                    KIND_WAN:  r_wan_cnt  <= r_wan_cnt + 1'b1;
                    KIND_LAN:  r_lan_cnt  <= r_lan_cnt + 1'b1;
                    default:   r_port_cnt <= r_port_cnt + 1'b1;
                endcase
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            unique case (i_cmd.kind)
                KIND_WAN: begin
                    r_wan_val[r_wan_cnt[IDX_W-1:0]] <= i_cmd.value;
                    r_wan_eq[r_wan_cnt[IDX_W-1:0]]  <= (i_cmd.opc == OP_EQ);
                end
                KIND_LAN: begin
                    r_lan_val[r_lan_cnt[IDX_W-1:0]] <= i_cmd.value;
                    r_lan_eq[r_lan_cnt[IDX_W-1:0]]  <= (i_cmd.opc == OP_EQ);
                end
                default: begin
                    r_port_val[r_port_cnt[IDX_W-1:0]] <= i_cmd.value;
                    r_port_op[r_port_cnt[IDX_W-1:0]]  <= i_cmd.opc;
                end
            endcase
        end
        if (o_pop) begin
            r_status  <= n_status;
            r_matched <= n_matched;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_matched, r_status};

endmodule

// File: src/packet_rule_filter_match.sv
// Top level: packet rule filter with decoupled decode and execute ends.
`timescale 1ns / 1ps
// Usage:
//   Slave stream carries commands. tuser selects the command (add rule or
//   match connection) and the rule table; tdata carries the rule and the
//   connection fields. Each beat yields exactly one master beat with a
//   status code (add) or a matched flag (match).
//   A beat accepted on the slave side is written into the command queue and
//   then into the result register, which drives the master side.
//   Throughput: one beat per cycle while the master accepts; the back end
//   compares a match against all stored rules of every table in parallel.
//   A two-entry command queue sits between decode and execute. When the
//   master stalls, the result register holds, the queue fills, and tready
//   drops once two more beats are waiting.
//   Reset (synchronous, active low) empties all rule tables and the queue
//   and clears pass_all. The user writes the pass_all register through
//   i_cfg_wr_en / i_cfg_wr_data only while idle; the block does not enforce it.
module packet_rule_filter_match
    import prfm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] rule_operator, [34:3] rule_value, [66:35] wan_addr, [67] wan_present,
    // [99:68] lan_addr, [100] lan_present, [116:101] port_number,
    // [117] port_present, [119:118] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] op, [2:1] rule_kind
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [2] matched, [7:3] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic r_pass_all;
    logic push, pop, q_full, q_empty;
    t_cmd front_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_all <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_pass_all <= i_cfg_wr_data;
        end
    end

    prfm_front u_front (
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    prfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    prfm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pass_all (r_pass_all),
        .i_q_empty  (q_empty),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("queue written while full");

    a_pass_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && q_cmd.is_match && r_pass_all) |=> (m_axis_tvalid && m_axis_tdata[2]))
        else $error("pass_all match did not report matched");

    a_result_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) &&
                          !(m_axis_tdata[2] && (m_axis_tdata[1:0] != ST_OK)))
        else $error("illegal result beat");

endmodule
